// File: rtl/pphr_pkg.sv
// Package for the printer port handshake receiver.
// Holds the word types, register types, phase codes and byte constants.
// No dependencies; every other file uses it by scoped names.
package pphr_pkg;

	// Transfer phase codes
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_HOLD    = 3'd1;
	localparam logic [2:0] PH_BIT     = 3'd2;
	localparam logic [2:0] PH_GAP     = 3'd3;
	localparam logic [2:0] PH_MATCH   = 3'd4;
	localparam logic [2:0] PH_RELEASE = 3'd5;
	localparam logic [2:0] PH_REJECT  = 3'd6;

	// Configuration register indexes
	localparam logic [7:0] REG_OWN_CODE   = 8'd0;
	localparam logic [7:0] REG_START_HOLD = 8'd1;
	localparam logic [7:0] REG_BIT_GAP    = 8'd2;
	localparam logic [7:0] REG_RELEASE    = 8'd3;

	// Register reset values
	localparam logic [7:0] OWN_CODE_RST   = 8'h0F;
	localparam logic [5:0] START_HOLD_RST = 6'd30;
	localparam logic [5:0] BIT_GAP_RST    = 6'd2;
	localparam logic [5:0] RELEASE_RST    = 6'd9;

	// Millisecond counter saturation
	localparam logic [5:0] MS_MAX = 6'd63;

	// Codes that leave the idle receiver enabled
	localparam logic [7:0] CODE_NONE  = 8'h00;
	localparam logic [7:0] CODE_ALL   = 8'hFF;
	localparam logic [7:0] CODE_PRN   = 8'h0F;
	localparam logic [7:0] CODE_ALT_A = 8'h21;
	localparam logic [7:0] CODE_ALT_B = 8'h45;

	// Control filter bytes
	localparam logic [7:0] CHR_SI    = 8'h0F;
	localparam logic [7:0] CHR_SO    = 8'h0E;
	localparam logic [7:0] CHR_ETX   = 8'h03;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	// One sample word
	typedef struct packed {
		logic busy_req;
		logic data_out;
		logic motor_out;
		logic select_one;
		logic ms_tick;
	} smp_t;

	// One result word
	typedef struct packed {
		logic       ack;
		logic       char_valid;
		logic [7:0] char_code;
		logic [2:0] phase;
	} res_t;

	// Configuration registers
	typedef struct packed {
		logic [7:0] own_device_code;
		logic [5:0] start_hold_ms;
		logic [5:0] bit_gap_ms;
		logic [5:0] release_ms;
	} cfg_t;

	// Receiver state
	typedef struct packed {
		logic [2:0] transfer_phase;
		logic [7:0] shift_byte;
		logic [2:0] bit_count;
		logic [5:0] elapsed_ms;
		logic [7:0] received_code;
		logic       ack_level;
		logic       control_pending;
		logic       prev_busy;
		logic       prev_motor;
	} st_t;

endpackage

// File: rtl/pphr_ifs.sv
// Channel interfaces for the printer port handshake receiver.
// Sample, result and configuration write channels; depends on pphr_pkg.

interface pphr_smp_if;
	logic               valid;
	logic               ready;
	pphr_pkg::smp_t     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pphr_res_if;
	logic               valid;
	logic               ready;
	pphr_pkg::res_t     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pphr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/pphr_step.sv
// Next-state logic of the printer port handshake receiver for one sample.
// Purely combinational; depends on pphr_pkg.
module pphr_step (
	input  pphr_pkg::st_t  st,
	input  pphr_pkg::cfg_t cfg,
	input  pphr_pkg::smp_t smp,
	output pphr_pkg::st_t  st_nxt,
	output pphr_pkg::res_t res
);

	always_comb begin
		pphr_pkg::st_t s;
		logic          unused_phase;
		logic          cvalid;
		logic [7:0]    ccode;
		logic [7:0]    shifted;
		logic [2:0]    cnt_inc;
		logic          rx_enable;

		s            = st;
		unused_phase = 1'b0;
		cvalid       = 1'b0;
		ccode        = 8'h00;

		// Saturating millisecond counter
		if (smp.ms_tick && (s.elapsed_ms != pphr_pkg::MS_MAX)) begin
			s.elapsed_ms = s.elapsed_ms + 6'd1;
		end

		// Device-code transfer sequencer
		shifted = {smp.data_out, s.shift_byte[7:1]};
		cnt_inc = s.bit_count + 3'd1;
		case (s.transfer_phase)
			pphr_pkg::PH_IDLE: begin
				if (smp.motor_out && smp.data_out) begin
					s.elapsed_ms     = 6'd0;
					s.transfer_phase = pphr_pkg::PH_HOLD;
					s.shift_byte     = 8'h00;
					s.bit_count      = 3'd0;
				end
			end
			pphr_pkg::PH_HOLD: begin
				if (smp.motor_out && smp.data_out) begin
					if (s.elapsed_ms > cfg.start_hold_ms) begin
						s.transfer_phase = pphr_pkg::PH_BIT;
						s.ack_level      = 1'b1;
					end
				end else begin
					s.transfer_phase = pphr_pkg::PH_IDLE;
				end
			end
			pphr_pkg::PH_BIT: begin
				if (smp.busy_req) begin
					s.ack_level  = 1'b0;
					s.shift_byte = shifted;
					s.bit_count  = cnt_inc;
					if (cnt_inc == 3'd0) begin
						s.received_code = shifted;
						if (shifted == cfg.own_device_code) begin
							s.transfer_phase = pphr_pkg::PH_MATCH;
						end else begin
							s.transfer_phase = pphr_pkg::PH_REJECT;
							s.elapsed_ms     = 6'd0;
						end
						s.shift_byte = 8'h00;
						s.bit_count  = 3'd0;
					end else begin
						s.transfer_phase = pphr_pkg::PH_GAP;
						s.elapsed_ms     = 6'd0;
					end
				end
			end
			pphr_pkg::PH_GAP: begin
				if (s.elapsed_ms > cfg.bit_gap_ms) begin
					s.transfer_phase = pphr_pkg::PH_BIT;
					s.ack_level      = 1'b1;
				end
			end
			pphr_pkg::PH_MATCH: begin
				if (!smp.busy_req && !smp.motor_out) begin
					s.ack_level      = 1'b1;
					s.transfer_phase = pphr_pkg::PH_RELEASE;
					s.elapsed_ms     = 6'd0;
					s.shift_byte     = 8'h00;
					s.bit_count      = 3'd0;
				end
			end
			pphr_pkg::PH_RELEASE: begin
				if (s.elapsed_ms > cfg.release_ms) begin
					s.ack_level      = 1'b0;
					s.transfer_phase = pphr_pkg::PH_IDLE;
					s.elapsed_ms     = 6'd0;
				end
			end
			pphr_pkg::PH_REJECT: begin
				if ((s.elapsed_ms > cfg.bit_gap_ms) && smp.busy_req) begin
					s.ack_level      = 1'b0;
					s.transfer_phase = pphr_pkg::PH_IDLE;
				end
			end
			default: begin
				s.transfer_phase = pphr_pkg::PH_IDLE;
				unused_phase     = 1'b1;
			end
		endcase

		// Idle receiver runs only for the known device codes
		rx_enable = !unused_phase && (s.transfer_phase == pphr_pkg::PH_IDLE) &&
			((s.received_code == pphr_pkg::CODE_NONE) ||
			 (s.received_code == pphr_pkg::CODE_ALL) ||
			 (s.received_code == pphr_pkg::CODE_PRN) ||
			 (s.received_code == pphr_pkg::CODE_ALT_A) ||
			 (s.received_code == pphr_pkg::CODE_ALT_B));

		if (rx_enable) begin
			// Acknowledge timeout with all lines quiet
			if (!smp.busy_req && !s.prev_busy && !smp.motor_out && !s.prev_motor &&
				s.ack_level && (s.elapsed_ms > cfg.bit_gap_ms)) begin
				s.elapsed_ms = 6'd0;
				s.ack_level  = 1'b0;
			end
			if (smp.select_one) begin
				s.shift_byte = 8'h00;
				s.bit_count  = 3'd0;
			end
			// Every busy toggle answers with an acknowledge toggle
			if (smp.busy_req != s.prev_busy) begin
				if (s.ack_level) begin
					s.ack_level = 1'b0;
				end else begin
					s.ack_level  = 1'b1;
					s.elapsed_ms = 6'd0;
				end
				if (smp.busy_req) begin
					s.shift_byte = {smp.data_out, s.shift_byte[7:1]};
					s.bit_count  = s.bit_count + 3'd1;
					if (s.bit_count == 3'd0) begin
						// Control filter: SI, SO, ETX arm the flag; a space clears it
						if (s.control_pending && (s.shift_byte == pphr_pkg::CHR_SPACE)) begin
							s.control_pending = 1'b0;
							cvalid            = 1'b1;
						end else if ((s.shift_byte == pphr_pkg::CHR_SI) ||
							(s.shift_byte == pphr_pkg::CHR_SO) ||
							(s.shift_byte == pphr_pkg::CHR_ETX)) begin
							s.control_pending = 1'b1;
						end else begin
							cvalid = 1'b1;
						end
						if (cvalid) begin
							ccode = s.shift_byte;
						end
						s.shift_byte = 8'h00;
						s.bit_count  = 3'd0;
					end
				end
			end
			s.prev_busy  = smp.busy_req;
			s.prev_motor = smp.motor_out;
		end

		st_nxt         = s;
		res.ack        = s.ack_level;
		res.char_valid = cvalid;
		res.char_code  = ccode;
		res.phase      = s.transfer_phase;
	end

endmodule

// File: rtl/printer_port_handshake_receiver_unit.sv
// Printer port handshake receiver, top level.
// Usage:
//   sample: one word per gated sample of the host's busy, data, motor and
//     select lines plus a millisecond tick flag; taken when valid and ready.
//   result: one word per sample with the acknowledge level, an optional
//     printable character and the transfer phase.
//   cfg: register writes (index 0 own device code, 1 start hold ms,
//     2 bit gap ms, 3 release ms); always ready; other indexes are ignored.
//     Write only while no sample is in flight.
// Throughput is one sample per clock while the skid word is empty; the whole
// state update is one pass of the step logic from the state register. Each result
// goes to an output register; a one-word skid stage lets one more sample in while
// the sink stalls; sample.ready drops only while the skid word is occupied, so
// results are never lost or reordered.
// Reset (arst_n low) clears the state to idle with acknowledge low, empties
// the output words and loads the register defaults (0x0F, 30, 2, 9).
// Depends on pphr_pkg, pphr_ifs and pphr_step.
module printer_port_handshake_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	pphr_smp_if.sink    sample,
	pphr_res_if.source  result,
	pphr_cfg_if.sink    cfg
);

	pphr_pkg::cfg_t cfg_q;
	pphr_pkg::st_t  st_q;
	pphr_pkg::st_t  st_nxt;
	pphr_pkg::res_t res_nxt;
	pphr_pkg::res_t out_q;
	pphr_pkg::res_t skid_q;
	logic           out_valid_q;
	logic           skid_valid_q;
	logic           in_fire;
	logic           out_open;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_device_code <= pphr_pkg::OWN_CODE_RST;
			cfg_q.start_hold_ms   <= pphr_pkg::START_HOLD_RST;
			cfg_q.bit_gap_ms      <= pphr_pkg::BIT_GAP_RST;
			cfg_q.release_ms      <= pphr_pkg::RELEASE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				pphr_pkg::REG_OWN_CODE:   cfg_q.own_device_code <= cfg.wdata;
				pphr_pkg::REG_START_HOLD: cfg_q.start_hold_ms   <= cfg.wdata[5:0];
				pphr_pkg::REG_BIT_GAP:    cfg_q.bit_gap_ms      <= cfg.wdata[5:0];
				pphr_pkg::REG_RELEASE:    cfg_q.release_ms      <= cfg.wdata[5:0];
				default: ;
			endcase
		end
	end

	// Step logic
	pphr_step u_step (
		.st     (st_q),
		.cfg    (cfg_q),
		.smp    (sample.data),
		.st_nxt (st_nxt),
		.res    (res_nxt)
	);

	assign sample.ready = !skid_valid_q;
	assign in_fire      = sample.valid && !skid_valid_q;
	assign out_open     = !out_valid_q || result.ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_fire) begin
			st_q <= st_nxt;
		end
	end

	// Output word and skid word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_open) begin
				out_valid_q  <= skid_valid_q || in_fire;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_open) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_fire) begin
				out_q <= res_nxt;
			end
		end else if (in_fire) begin
			skid_q <= res_nxt;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// Checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word held without an output word");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && out_valid_q && !result.ready) |=> skid_valid_q)
		else $error("sample taken during stall was not parked");

	a_char_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.char_valid) |-> (out_q.phase == pphr_pkg::PH_IDLE))
		else $error("character emitted outside idle phase");

	a_no_control_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.char_valid) |->
		((out_q.char_code != pphr_pkg::CHR_SI) && (out_q.char_code != pphr_pkg::CHR_SO) &&
		 (out_q.char_code != pphr_pkg::CHR_ETX)))
		else $error("control character passed the filter");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the printer port handshake receiver: drives sampled host lines,
// predicts every result word and checks it field by field. Depends on pphr_pkg,
// pphr_ifs and the printer_port_handshake_receiver_unit RTL.
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL  = 300;
	localparam int PRINT_LIMIT = 100;

	logic clk;
	logic arst_n;

	pphr_smp_if sample_ch ();
	pphr_res_if result_ch ();
	pphr_cfg_if cfg_ch ();

	printer_port_handshake_receiver_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Register copy used by the line model and the sequence generator
	logic [7:0] cfg_own  = pphr_pkg::OWN_CODE_RST;
	logic [5:0] cfg_hold = pphr_pkg::START_HOLD_RST;
	logic [5:0] cfg_gap  = pphr_pkg::BIT_GAP_RST;
	logic [5:0] cfg_rel  = pphr_pkg::RELEASE_RST;

	// Line model state
	logic [2:0] cur_phase    = pphr_pkg::PH_IDLE;
	logic [7:0] rx_shift     = '0;
	logic [2:0] rx_bits      = '0;
	logic [5:0] ms_count     = '0;
	logic [7:0] last_code    = '0;
	logic       ack_out      = 1'b0;
	logic       ctrl_armed   = 1'b0;
	logic       prev_busy_q  = 1'b0;
	logic       prev_motor_q = 1'b0;

	pphr_pkg::smp_t host_samples[$];
	pphr_pkg::res_t expected_responses[$];
	pphr_pkg::res_t oldest_response;

	bit offer_busy      = 1'b0;
	bit feed_hold       = 1'b0;
	bit sink_hold       = 1'b0;
	bit long_stall_arm  = 1'b0;
	bit long_stall_done = 1'b0;
	int stall_count     = 0;
	int src_idle_pct    = 0;
	int sink_idle_pct   = 0;
	int error_count     = 0;
	int response_count  = 0;
	int cycle_count     = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Shift one data bit in at the top, LSB first; true when a byte is complete
	function automatic logic shift_bit(input logic b);
		rx_shift = {b, rx_shift[7:1]};
		rx_bits  = rx_bits + 3'd1;
		return rx_bits == 3'd0;
	endfunction

	// One sample step of the receiver: handshake phases, then the idle receiver
	function automatic pphr_pkg::res_t predict_line_response(input pphr_pkg::smp_t s);
		pphr_pkg::res_t r;
		logic skip_idle;
		r = '0;
		skip_idle = 1'b0;
		if (s.ms_tick && ms_count != pphr_pkg::MS_MAX)
			ms_count = ms_count + 6'd1;

		case (cur_phase)
			pphr_pkg::PH_IDLE: begin
				if (s.motor_out && s.data_out) begin
					ms_count  = '0;
					cur_phase = pphr_pkg::PH_HOLD;
					rx_shift  = '0;
					rx_bits   = '0;
				end
			end
			pphr_pkg::PH_HOLD: begin
				if (s.motor_out && s.data_out) begin
					if (ms_count > cfg_hold) begin
						cur_phase = pphr_pkg::PH_BIT;
						ack_out   = 1'b1;
					end
				end else begin
					cur_phase = pphr_pkg::PH_IDLE;
				end
			end
			pphr_pkg::PH_BIT: begin
				if (s.busy_req) begin
					ack_out = 1'b0;
					if (shift_bit(s.data_out)) begin
						last_code = rx_shift;
						if (rx_shift == cfg_own) begin
							cur_phase = pphr_pkg::PH_MATCH;
						end else begin
							cur_phase = pphr_pkg::PH_REJECT;
							ms_count  = '0;
						end
						rx_shift = '0;
						rx_bits  = '0;
					end else begin
						cur_phase = pphr_pkg::PH_GAP;
						ms_count  = '0;
					end
				end
			end
			pphr_pkg::PH_GAP: begin
				if (ms_count > cfg_gap) begin
					cur_phase = pphr_pkg::PH_BIT;
					ack_out   = 1'b1;
				end
			end
			pphr_pkg::PH_MATCH: begin
				if (!s.busy_req && !s.motor_out) begin
					ack_out   = 1'b1;
					cur_phase = pphr_pkg::PH_RELEASE;
					ms_count  = '0;
					rx_shift  = '0;
					rx_bits   = '0;
				end
			end
			pphr_pkg::PH_RELEASE: begin
				if (ms_count > cfg_rel) begin
					ack_out   = 1'b0;
					cur_phase = pphr_pkg::PH_IDLE;
					ms_count  = '0;
				end
			end
			pphr_pkg::PH_REJECT: begin
				if (ms_count > cfg_gap && s.busy_req) begin
					ack_out   = 1'b0;
					cur_phase = pphr_pkg::PH_IDLE;
				end
			end
			default: begin
				// unused phase: back to idle, nothing else this step
				cur_phase = pphr_pkg::PH_IDLE;
				skip_idle = 1'b1;
			end
		endcase

		// Idle receiver, gated by the last transferred device code
		if (!skip_idle && cur_phase == pphr_pkg::PH_IDLE &&
		    (last_code inside {pphr_pkg::CODE_NONE, pphr_pkg::CODE_ALL, pphr_pkg::CODE_PRN,
		                       pphr_pkg::CODE_ALT_A, pphr_pkg::CODE_ALT_B})) begin
			if (!s.busy_req && !prev_busy_q && !s.motor_out && !prev_motor_q &&
			    ack_out && ms_count > cfg_gap) begin
				ms_count = '0;
				ack_out  = 1'b0;
			end
			if (s.select_one) begin
				rx_shift = '0;
				rx_bits  = '0;
			end
			if (s.busy_req != prev_busy_q) begin
				if (ack_out) begin
					ack_out = 1'b0;
				end else begin
					ack_out  = 1'b1;
					ms_count = '0;
				end
				if (s.busy_req) begin
					if (shift_bit(s.data_out)) begin
						// control filter: SI/SO/ETX arm the flag, a space after it passes
						if (ctrl_armed && rx_shift == pphr_pkg::CHR_SPACE) begin
							ctrl_armed   = 1'b0;
							r.char_valid = 1'b1;
							r.char_code  = rx_shift;
						end else if (rx_shift inside {pphr_pkg::CHR_SI, pphr_pkg::CHR_SO,
						                              pphr_pkg::CHR_ETX}) begin
							ctrl_armed = 1'b1;
						end else begin
							r.char_valid = 1'b1;
							r.char_code  = rx_shift;
						end
						rx_shift = '0;
						rx_bits  = '0;
					end
				end
			end
			prev_busy_q  = s.busy_req;
			prev_motor_q = s.motor_out;
		end

		r.ack   = ack_out;
		r.phase = cur_phase;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (error_count < PRINT_LIMIT)
			$display("[tb] result %0d: %s is %0h, expected %0h", response_count, what, got, want);
		error_count++;
	endtask

	// Sample driver: offers queued words, holds each until it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_responses.push_back(predict_line_response(sample_ch.data));
				offer_busy = 1'b0;
			end
			if (!offer_busy) begin
				if (host_samples.size() != 0 && !feed_hold &&
				    $urandom_range(99) >= src_idle_pct) begin
					sample_ch.data  <= host_samples.pop_front();
					sample_ch.valid <= 1'b1;
					offer_busy = 1'b1;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and sink ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_responses.size() == 0) begin
					report_mismatch("unexpected word", int'(result_ch.data), 0);
				end else begin
					oldest_response = expected_responses.pop_front();
					if (result_ch.data.ack !== oldest_response.ack)
						report_mismatch("ack", int'(result_ch.data.ack), int'(oldest_response.ack));
					if (result_ch.data.char_valid !== oldest_response.char_valid)
						report_mismatch("char_valid", int'(result_ch.data.char_valid),
							int'(oldest_response.char_valid));
					if (result_ch.data.char_code !== oldest_response.char_code)
						report_mismatch("char_code", int'(result_ch.data.char_code),
							int'(oldest_response.char_code));
					if (result_ch.data.phase !== oldest_response.phase)
						report_mismatch("phase", int'(result_ch.data.phase),
							int'(oldest_response.phase));
				end
				response_count++;
			end
			result_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Long sink hold-off, counted here once armed
	always @(posedge clk) begin
		if (long_stall_arm && !long_stall_done) begin
			if (stall_count == LONG_STALL) begin
				long_stall_done <= 1'b1;
				sink_hold       <= 1'b0;
			end else begin
				stall_count <= stall_count + 1;
				sink_hold   <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic rbit();
		return logic'($urandom_range(1));
	endfunction

	function automatic logic rtick();
		return $urandom_range(9) == 0;
	endfunction

	// Ticks needed to get past a wait; a wait at the ceiling never ends, so cut it short
	function automatic int wait_ticks(input logic [5:0] limit);
		if (limit == pphr_pkg::MS_MAX)
			return 6;
		return int'(limit) + 1 + int'($urandom_range(1));
	endfunction

	task automatic add_sample(input logic b, input logic d, input logic m, input logic s,
		input logic t);
		pphr_pkg::smp_t w;
		w.busy_req   = b;
		w.data_out   = d;
		w.motor_out  = m;
		w.select_one = s;
		w.ms_tick    = t;
		host_samples.push_back(w);
	endtask

	task automatic gen_noise(input int n);
		repeat (n) host_samples.push_back(pphr_pkg::smp_t'($urandom_range(31)));
	endtask

	// Device-code transfer: start hold, eight acknowledged bits, then release or reject.
	// A broken one is cut off during the hold or after some bits.
	task automatic gen_transfer(input logic [7:0] code, input bit broken);
		int cut;
		cut = broken ? int'($urandom_range(8)) : 99;
		add_sample(1'b0, 1'b1, 1'b1, 1'b0, rbit());
		if (cut == 0) begin
			repeat ($urandom_range(3)) add_sample(1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
			add_sample(1'b0, rbit(), 1'b0, 1'b0, rbit());
			return;
		end
		repeat (wait_ticks(cfg_hold)) add_sample(rbit(), 1'b1, 1'b1, 1'b0, 1'b1);
		for (int i = 0; i < 8; i++) begin
			add_sample(1'b1, code[i], rbit(), rbit(), rbit());
			if (cut == i + 1)
				return;
			if (i < 7)
				repeat (wait_ticks(cfg_gap)) add_sample(1'b0, rbit(), rbit(), rbit(), 1'b1);
		end
		if (code == cfg_own) begin
			add_sample(1'b0, rbit(), 1'b0, rbit(), rbit());
			repeat (wait_ticks(cfg_rel)) add_sample(1'b0, rbit(), 1'b0, rbit(), 1'b1);
		end else begin
			repeat (wait_ticks(cfg_gap)) add_sample(1'b1, rbit(), 1'b0, rbit(), 1'b1);
		end
	endtask

	// One byte on the idle receiver: busy toggles, data taken on each rising busy.
	// With a glitch, select is raised on one bit and restarts the byte.
	task automatic gen_char(input logic [7:0] ch, input bit glitch);
		int k;
		k = glitch ? int'($urandom_range(7)) : 99;
		add_sample(1'b0, rbit(), 1'b0, 1'b0, rtick());
		for (int i = 0; i < 8; i++) begin
			add_sample(1'b1, ch[i], 1'b0, logic'(i == k), rtick());
			add_sample(1'b0, rbit(), 1'b0, 1'b0, rtick());
		end
	endtask

	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return cfg_own;
		if (r < 85) begin
			case ($urandom_range(4))
				0: return pphr_pkg::CODE_NONE;
				1: return pphr_pkg::CODE_ALL;
				2: return pphr_pkg::CODE_PRN;
				3: return pphr_pkg::CODE_ALT_A;
				default: return pphr_pkg::CODE_ALT_B;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return pphr_pkg::CHR_SI;
		if (r < 20)
			return pphr_pkg::CHR_SO;
		if (r < 30)
			return pphr_pkg::CHR_ETX;
		if (r < 55)
			return pphr_pkg::CHR_SPACE;
		return 8'($urandom_range(255));
	endfunction

	// Queue a batch of mostly well-formed sequences with some noise and broken ones
	task automatic gen_batch(input int target);
		int base;
		int r;
		base = host_samples.size();
		while (host_samples.size() - base < target) begin
			r = $urandom_range(99);
			if (r < 40)
				gen_char(pick_char(), 1'b0);
			else if (r < 50)
				gen_char(pick_char(), 1'b1);
			else if (r < 72)
				gen_transfer(pick_code(), 1'b0);
			else if (r < 82)
				gen_transfer(pick_code(), 1'b1);
			else
				gen_noise($urandom_range(1, 6));
		end
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			pphr_pkg::REG_OWN_CODE:   cfg_own  = val;
			pphr_pkg::REG_START_HOLD: cfg_hold = val[5:0];
			pphr_pkg::REG_BIT_GAP:    cfg_gap  = val[5:0];
			pphr_pkg::REG_RELEASE:    cfg_rel  = val[5:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [7:0] own, input logic [7:0] hold,
		input logic [7:0] gap, input logic [7:0] rel);
		write_reg(pphr_pkg::REG_OWN_CODE, own);
		write_reg(pphr_pkg::REG_START_HOLD, hold);
		write_reg(pphr_pkg::REG_BIT_GAP, gap);
		write_reg(pphr_pkg::REG_RELEASE, rel);
	endtask

	// Wait until every queued word is taken and every result is back
	task automatic drain();
		@(negedge clk);
		while (host_samples.size() != 0 || offer_busy || expected_responses.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_idling(input int src_pct, input int sink_pct);
		@(negedge clk);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	// Main sequence
	initial begin
		arst_n          = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		result_ch.ready = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = '0;
		cfg_ch.wdata    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes at the reset register values
		set_idling(35, 75);
		add_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
		add_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
		add_sample(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
		drain();

		// Directed: accepted transfer at the shortest timing
		write_all(pphr_pkg::CODE_ALT_B, 8'd0, 8'd0, 8'd0);
		gen_transfer(pphr_pkg::CODE_ALT_B, 1'b0);
		drain();

		write_all(pphr_pkg::OWN_CODE_RST, 8'(pphr_pkg::START_HOLD_RST),
			8'(pphr_pkg::BIT_GAP_RST), 8'(pphr_pkg::RELEASE_RST));
		gen_batch(150);
		drain();

		write_all(pphr_pkg::CODE_ALL, 8'd0, 8'd0, 8'd0);
		gen_batch(130);
		drain();

		set_idling(75, 35);
		write_all(pphr_pkg::CODE_ALT_A, 8'd2, 8'd1, 8'd3);
		gen_batch(130);
		drain();

		// release at the ceiling: an accepted code keeps acknowledge high
		write_all(pphr_pkg::CODE_ALL, 8'd1, 8'd1, 8'h7F);
		gen_batch(80);
		drain();

		// hold and gap at the ceiling; writes outside the register set are ignored
		write_all(pphr_pkg::CODE_ALT_B, 8'hFF, 8'hBF, 8'hC1);
		write_reg(8'h04, 8'h55);
		write_reg(8'hFF, 8'hAA);
		gen_batch(60);
		drain();

		// No idling; the sink holds off long enough to fill the block
		set_idling(0, 0);
		write_all(pphr_pkg::CODE_NONE, 8'd3, 8'd2, 8'd2);
		long_stall_arm = 1'b1;
		gen_batch(130);
		drain();

		write_all(8'($urandom_range(255)), 8'($urandom_range(4)), 8'($urandom_range(3)),
			8'($urandom_range(4)));
		gen_batch(170);
		drain();

		repeat (10) @(negedge clk);
		if (error_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
